// ===== sv/c1ks_pkg.sv =====
// c1ks_pkg: shared types, constants and functions of the crypto-1 keystream generator
// filter tables, feedback taps, command codes and the key split
// no dependencies
`timescale 1ns / 1ps

package c1ks_pkg;

	// feedback taps of the two 24-bit halves
	localparam logic [23:0] POLY_ODD  = 24'h29CE5C;
	localparam logic [23:0] POLY_EVEN = 24'h870804;

	// first-level filter tables, one per input nibble
	localparam logic [19:0] FILT_A = 20'hF22C0;
	localparam logic [19:0] FILT_B = 20'h6C9C0;
	localparam logic [19:0] FILT_C = 20'h3C8B0;
	localparam logic [19:0] FILT_D = 20'h1E458;
	localparam logic [19:0] FILT_E = 20'h0D938;

	// second-level filter table
	localparam logic [31:0] FILT_OUT = 32'hEC57E80A;

	// word mode walks the bytes in reverse order
	localparam logic [4:0] WORD_SWAP = 5'd24;

	// last clock index of each clocking command
	localparam logic [4:0] LAST_BIT  = 5'd0;
	localparam logic [4:0] LAST_BYTE = 5'd7;
	localparam logic [4:0] LAST_WORD = 5'd31;

	// command codes
	typedef enum logic [2:0] {
		CMD_LOAD  = 3'd0,
		CMD_CLEAR = 3'd1,
		CMD_BIT   = 3'd2,
		CMD_BYTE  = 3'd3,
		CMD_WORD  = 3'd4
	} cmd_t;

	// cipher state
	typedef struct packed {
		logic [23:0] odd_half;
		logic [23:0] even_half;
	} halves_t;

	// request to the round unit
	typedef struct packed {
		halves_t st;
		logic    in_bit;
		logic    feed_output;
	} round_in_t;

	// answer of the round unit
	typedef struct packed {
		halves_t st;
		logic    ks;
	} round_out_t;

	// nonlinear filter over bits 19:0 of the odd half
	function automatic logic filt(input logic [23:0] x);
		logic [4:0] f;
		f[4] = FILT_A[{1'b0, x[3:0]} + 5'd4];
		f[3] = FILT_B[{1'b0, x[7:4]} + 5'd3];
		f[2] = FILT_C[{1'b0, x[11:8]} + 5'd2];
		f[1] = FILT_D[{1'b0, x[15:12]} + 5'd1];
		f[0] = FILT_E[{1'b0, x[19:16]}];
		return FILT_OUT[f];
	endfunction

	// key bits interleaved into the halves, bytes bit-reversed
	function automatic halves_t key_split(input logic [47:0] key);
		halves_t h;
		for (int j = 0; j < 24; j++) begin
			h.odd_half[j]  = key[(2 * j) ^ 7];
			h.even_half[j] = key[(2 * j + 1) ^ 7];
		end
		return h;
	endfunction

endpackage

// ===== sv/crypto1_keystream_generator.sv =====
// crypto1_keystream_generator: top level of the crypto-1 keystream generator
// holds the key register, cipher state, sequencer and output register
// depends on c1ks_pkg and c1ks_round
`timescale 1ns / 1ps

// Usage
// key channel: key_valid/key_ready carry cipher_key; key_ready is always high.
//   Write the key only while no command is in flight.
// input channel: in_valid with cmd, data_in, feed_output; the block raises in_stall
//   while a command is in flight. Commands: load key, clear, clock 1, 8 or 32 times.
// output channel: out_valid with keystream and parity_bit, one transaction per
//   command; the receiver holds it with out_stall and the result stays put.
// Timing: one cipher clock per cycle through a single round unit.
// The next command is accepted as soon as the result is in the output register,
//   even while it is still stalled; a new result waits until that one is taken.
// Reset (arst_n low) clears the key, both halves and all valid flags.

module crypto1_keystream_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_valid,
	output logic        key_ready,
	input  logic [47:0] cipher_key,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [31:0] data_in,
	input  logic        feed_output,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] keystream,
	output logic        parity_bit
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [47:0]          key_q;
	c1ks_pkg::halves_t    st_q;
	logic [31:0]          data_q;
	logic [31:0]          ks_q;
	logic                 fo_q;
	logic                 word_q;
	logic [4:0]           cnt_q;
	logic [4:0]           last_q;
	logic                 out_valid_q;
	logic [31:0]          keystream_q;
	logic                 parity_q;

	logic                 in_acc;
	logic                 slot_free;
	logic [4:0]           pos;
	c1ks_pkg::round_in_t  rin;
	c1ks_pkg::round_out_t rout;

	// handshakes
	assign key_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// bit position of the current clock
	assign pos = word_q ? (cnt_q ^ c1ks_pkg::WORD_SWAP) : cnt_q;

	// shared round unit
	assign rin.st          = st_q;
	assign rin.in_bit      = data_q[pos];
	assign rin.feed_output = fo_q;

	c1ks_round u_round (
		.rin  (rin),
		.rout (rout)
	);

	// key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (key_valid && key_ready) begin
			key_q <= cipher_key;
		end
	end

	// sequencer and cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= '0;
			cnt_q   <= '0;
			last_q  <= '0;
			word_q  <= 1'b0;
			fo_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cnt_q  <= '0;
						word_q <= (cmd == c1ks_pkg::CMD_WORD);
						fo_q   <= feed_output;
						case (cmd)
							c1ks_pkg::CMD_LOAD: begin
								st_q    <= c1ks_pkg::key_split(key_q);
								state_q <= ST_DONE;
							end
							c1ks_pkg::CMD_CLEAR: begin
								st_q    <= '0;
								state_q <= ST_DONE;
							end
							c1ks_pkg::CMD_BIT: begin
								last_q  <= c1ks_pkg::LAST_BIT;
								state_q <= ST_RUN;
							end
							c1ks_pkg::CMD_BYTE: begin
								last_q  <= c1ks_pkg::LAST_BYTE;
								state_q <= ST_RUN;
							end
							c1ks_pkg::CMD_WORD: begin
								last_q  <= c1ks_pkg::LAST_WORD;
								state_q <= ST_RUN;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RUN: begin
					st_q  <= rout.st;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == last_q) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// input data and keystream accumulation
	always_ff @(posedge clk) begin
		if (in_acc) begin
			data_q <= data_in;
			ks_q   <= '0;
		end else if (state_q == ST_RUN) begin
			ks_q[pos] <= rout.ks;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && slot_free) begin
			keystream_q <= ks_q;
			parity_q    <= c1ks_pkg::filt(st_q.odd_half);
		end
	end

	assign out_valid  = out_valid_q;
	assign keystream  = keystream_q;
	assign parity_bit = parity_q;

`ifndef SYNTHESIS
	// the clock counter never passes the command's last clock
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q <= last_q)
		else $error("clock counter beyond last clock");

	// an accepted command always leaves idle
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == ST_RUN || state_q == ST_DONE))
		else $error("accepted command did not start");

	// finishing a command fills the output register and frees the input
	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && slot_free |=> out_valid_q && state_q == ST_IDLE)
		else $error("finished command not delivered");
`endif

endmodule

// ===== sv/c1ks_round.sv =====
// c1ks_round: one cipher clock of the crypto-1 state, shared by every clocking command
// filter, feedback parity, shift and half swap
// depends on c1ks_pkg
`timescale 1ns / 1ps

module c1ks_round (
	input  c1ks_pkg::round_in_t  rin,
	output c1ks_pkg::round_out_t rout
);

	logic        ks;
	logic        fb;
	logic [23:0] shifted;

	// keystream bit from the odd half
	assign ks = c1ks_pkg::filt(rin.st.odd_half);

	// feedback: input bit, optional keystream bit, tapped state bits
	assign fb = (ks & rin.feed_output) ^ rin.in_bit
		^ (^(c1ks_pkg::POLY_ODD & rin.st.odd_half))
		^ (^(c1ks_pkg::POLY_EVEN & rin.st.even_half));

	assign shifted = {rin.st.even_half[22:0], fb};

	// shift into the even half, then swap
	assign rout.ks           = ks;
	assign rout.st.odd_half  = shifted;
	assign rout.st.even_half = rin.st.odd_half;

endmodule
